>>> sv/modular_exponentiation_top_defines.svh
// ---------------------------------------------------------------------------
// Modular exponentiation assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ---------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define MX_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("modexp assertion failed");
// Next-cycle implication.
`define MX_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("modexp assertion failed");
`else
`define MX_ASSERT_IMP(label, ante, cons)
`define MX_ASSERT_NXT(label, ante, cons)
`endif

`endif

>>> sv/modexp_pkg.sv
// ---------------------------------------------------------------------------
// Modular exponentiation package
// Word types, controller states and controller/datapath interface structs.
// ---------------------------------------------------------------------------
package modexp_pkg;

  localparam int DATA_W    = 32;
  localparam int WIDTH_DEF = 32;

  typedef struct packed {
    logic [DATA_W-1:0] base_value;
    logic [DATA_W-1:0] exponent;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] residue;
    logic              bad_modulus;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_REDUCE_WAIT,
    ST_CHECK,
    ST_ACC_WAIT,
    ST_SQR_WAIT,
    ST_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_REDUCE,
    SEL_ACC,
    SEL_SQR
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     shift_exp;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mod_zero;
    logic exp_zero;
    logic exp_lsb;
    logic mul_busy;
    logic mul_done;
    logic out_free;
  } dp_status_t;

endpackage

>>> sv/modexp_mulmod.sv
// ---------------------------------------------------------------------------
// Bit-serial modular multiplier
// Interleaved shift-and-add: one bit of b per cycle, MSB first, reduced by m.
// ---------------------------------------------------------------------------
module modexp_mulmod #(
  parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [WIDTH-1:0]              a,
  input  logic [modexp_pkg::DATA_W-1:0] b,
  input  logic [WIDTH-1:0]              m,
  output logic [WIDTH-1:0]              result,
  output logic                          busy,
  output logic                          done
);
  import modexp_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic [WIDTH-1:0]  a_r;
  logic [DATA_W-1:0] b_r, b_nxt;
  logic [WIDTH-1:0]  r_r, r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [WIDTH:0]    dbl, dbl_red, sum, sum_red;
  logic [WIDTH-1:0]  addend;

  // The partial result stays below m, and a is at most m, so both the doubled
  // value and the sum stay below 2m: one conditional subtract each.
  always_comb begin
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    addend  = b_r[DATA_W-1] ? a_r : '0;
    sum     = dbl_red + {1'b0, addend};
    sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
  end

  always_comb begin
    b_nxt    = b_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      b_nxt    = b;
      r_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      b_nxt   = {b_r[DATA_W-2:0], 1'b0};
      r_nxt   = sum_red[WIDTH-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
    end
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign result = r_r;
  assign busy   = busy_r;
  assign done   = done_r;

endmodule

>>> sv/modexp_dp.sv
// ---------------------------------------------------------------------------
// Modular exponentiation datapath
// Modulus, operand and accumulator registers, the multiplier and the output
// register.
// ---------------------------------------------------------------------------
module modexp_dp #(
  parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [modexp_pkg::DATA_W-1:0] cfg_data,
  input  modexp_pkg::in_word_t          in_data,
  input  modexp_pkg::ctrl_cmd_t         cmd,
  output modexp_pkg::dp_status_t        status,
  input  logic                          out_ready,
  output logic                          out_valid,
  output modexp_pkg::out_word_t         out_data
);
  import modexp_pkg::*;

  logic [WIDTH-1:0]  mod_r;
  logic [DATA_W-1:0] base_r;
  logic [DATA_W-1:0] exp_r;
  logic [WIDTH-1:0]  acc_r;
  logic [WIDTH-1:0]  pow_r;
  mul_sel_t          sel_r;
  out_word_t         out_r;
  logic              out_valid_r, out_valid_nxt;

  logic [WIDTH-1:0]  mul_a;
  logic [DATA_W-1:0] mul_b;
  logic [WIDTH-1:0]  mul_res;
  logic              mul_busy, mul_done;
  logic              mod_zero;

  assign mod_zero = (mod_r == '0);

  always_comb begin
    case (cmd.mul_sel)
      SEL_REDUCE: begin
        mul_a = WIDTH'(1);
        mul_b = base_r;
      end
      SEL_ACC: begin
        mul_a = pow_r;
        mul_b = DATA_W'(acc_r);
      end
      SEL_SQR: begin
        mul_a = pow_r;
        mul_b = DATA_W'(pow_r);
      end
      default: begin
        mul_a = pow_r;
        mul_b = DATA_W'(pow_r);
      end
    endcase
  end

  modexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (mod_r),
    .result (mul_res),
    .busy   (mul_busy),
    .done   (mul_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= '0;
    end else if (cfg_valid) begin
      mod_r <= cfg_data[WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r <= in_data.base_value;
      exp_r  <= in_data.exponent;
      // One modulo one is zero.
      acc_r  <= (mod_r == WIDTH'(1)) ? '0 : WIDTH'(1);
    end else begin
      if (cmd.shift_exp) begin
        exp_r <= {1'b0, exp_r[DATA_W-1:1]};
      end
      if (mul_done) begin
        case (sel_r)
          SEL_ACC: acc_r <= mul_res;
          default: pow_r <= mul_res;
        endcase
      end
    end
    if (cmd.mul_start) begin
      sel_r <= cmd.mul_sel;
    end
    if (cmd.out_load) begin
      out_r.residue     <= mod_zero ? '0 : DATA_W'(acc_r);
      out_r.bad_modulus <= mod_zero;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    status.mod_zero = mod_zero;
    status.exp_zero = (exp_r == '0);
    status.exp_lsb  = exp_r[0];
    status.mul_busy = mul_busy;
    status.mul_done = mul_done;
    status.out_free = !out_valid_r || out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

>>> sv/modexp_ctrl.sv
// ---------------------------------------------------------------------------
// Modular exponentiation controller
// Sequences base reduction and the square-and-multiply loop over exponent bits.
// ---------------------------------------------------------------------------
module modexp_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  modexp_pkg::dp_status_t status,
  output modexp_pkg::ctrl_cmd_t  cmd
);
  import modexp_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.mul_start = 1'b0;
    cmd.mul_sel   = SEL_SQR;
    cmd.shift_exp = 1'b0;
    cmd.out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (status.mod_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_REDUCE;
          state_nxt     = ST_REDUCE_WAIT;
        end
      end
      ST_REDUCE_WAIT: begin
        if (status.mul_done) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.exp_zero) begin
          state_nxt = ST_FINISH;
        end else if (status.exp_lsb) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_ACC;
          state_nxt     = ST_ACC_WAIT;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_SQR;
          state_nxt     = ST_SQR_WAIT;
        end
      end
      ST_ACC_WAIT: begin
        // The accumulator update leaves the power untouched, so squaring can
        // start in the same cycle.
        if (status.mul_done) begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = SEL_SQR;
          state_nxt     = ST_SQR_WAIT;
        end
      end
      ST_SQR_WAIT: begin
        if (status.mul_done) begin
          cmd.shift_exp = 1'b1;
          state_nxt     = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/modular_exponentiation_top.sv
// ---------------------------------------------------------------------------
// Modular exponentiation top level
// Computes base_value ^ exponent mod modulus by right-to-left
// square-and-multiply.
//
// The cfg channel writes the modulus (low WIDTH bits kept); it is always
// ready and must only be written while no word is in flight. Each in word
// carries a base and an exponent; each produces exactly one out word with
// the residue and a bad_modulus flag (residue 0 when the modulus is zero).
// The base is first reduced in one serial multiply. Each exponent bit up to
// the highest set one then costs a squaring, plus an accumulator multiply
// when set. The bit-serial multiplier takes one multiplier bit a cycle.
// A zero modulus skips the multiplies: the controller goes from the reduce
// state to the finish state, loads the result, then returns to idle.
// One word is processed at a time; in_ready is high only while the
// controller is idle. The result sits in an output register, so a new word
// is accepted while the previous result waits; a stalled receiver only holds
// the controller when the next result is ready to be written.
// Reset clears the modulus to zero and empties the output register.
// ---------------------------------------------------------------------------
`include "modular_exponentiation_top_defines.svh"

module modular_exponentiation_top #(
  parameter int WIDTH = modexp_pkg::WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [modexp_pkg::DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  modexp_pkg::in_word_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output modexp_pkg::out_word_t         out_data
);
  import modexp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  modexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  modexp_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  `MX_ASSERT_IMP(a_bad_mod_zero, out_valid && out_data.bad_modulus, out_data.residue == '0)
  `MX_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `MX_ASSERT_IMP(a_mul_start_idle, cmd.mul_start, !status.mul_busy)
  `MX_ASSERT_IMP(a_out_load_free, cmd.out_load, status.out_free)

endmodule

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// Modular exponentiation testbench
// Drives base/exponent words into the square-and-multiply block under a range
// of modulus settings and checks every residue against a behavioral model.
// The input side sends in bursts with random gaps, and the result side stalls
// on a pattern of its own.
// ---------------------------------------------------------------------------
module tb_top;
  import modexp_pkg::*;

  localparam int          MOD_W       = WIDTH_DEF;
  localparam int          DRAIN_WAIT  = 2300;
  localparam logic [63:0] RUN_LIMIT   = 64'd50_000_000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [DATA_W-1:0] cfg_data = '0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // Model copy of the modulus register, already masked to MOD_W bits.
  logic [63:0] modulus_model = '0;
  out_word_t   pending_residues[$];

  int error_count    = 0;
  int words_sent     = 0;
  int results_seen   = 0;
  int modulus_writes = 0;
  int burst_left     = 0;
  int ready_mode     = 0;
  int ready_left     = 0;

  modular_exponentiation_top #(.WIDTH(MOD_W)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial forever #5 clk = ~clk;

  function automatic out_word_t predict_power_mod(input logic [31:0] b, input logic [31:0] e);
    logic [63:0] acc;
    logic [63:0] pw;
    logic [31:0] ex;
    out_word_t   r;
    r = '0;
    if (modulus_model == 0) begin
      r.bad_modulus = 1'b1;
      return r;
    end
    acc = 64'd1 % modulus_model;
    pw  = {32'd0, b} % modulus_model;
    ex  = e;
    while (ex != 0) begin
      if (ex[0]) acc = (acc * pw) % modulus_model;
      pw = (pw * pw) % modulus_model;
      ex = ex >> 1;
    end
    r.residue = acc[31:0];
    return r;
  endfunction

  // Sends one word; valid is only lowered at the start of a gap, never right
  // before it is raised again in the same step.
  task automatic send_word(input logic [31:0] b, input logic [31:0] e);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) gap = $urandom_range(1, 2500);
      else gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= '{base_value: b, exponent: e};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_residues.push_back(predict_power_mod(b, e));
    words_sent++;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic write_modulus(input logic [31:0] value);
    logic [63:0] keep_mask;
    keep_mask = (64'd1 << MOD_W) - 64'd1;
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    modulus_model = {32'd0, value} & keep_mask;
    modulus_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_exponent();
    case ($urandom_range(0, 3))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 300);
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      4:       return $urandom_range(0, 3);
      5:       return (modulus_model > 0) ? modulus_model[31:0] - 32'd1 : 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // The modulus resets to zero, so the first words must be flagged.
  task automatic test_reset_modulus();
    send_word(32'd5, 32'd3);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_for_results();
  endtask

  task automatic test_tiny_moduli();
    write_modulus(32'd1);
    send_word(32'd0, 32'd0);
    send_word(32'd7, 32'd0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_for_results();
    write_modulus(32'd2);
    send_word(32'd0, 32'd0);
    send_word(32'd3, 32'd5);
    send_word(32'hFFFF_FFFF, 32'd1);
    wait_for_results();
  endtask

  task automatic test_wide_moduli();
    write_modulus(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFE, 32'd2);
    send_word(32'd0, 32'd0);
    send_word(32'd0, 32'd5);
    send_word(32'd12345, 32'd0);
    wait_for_results();
    // Largest 32-bit prime: Fermat gives 1 for base 2 raised to p-1.
    write_modulus(32'hFFFF_FFFB);
    send_word(32'd2, 32'hFFFF_FFFA);
    send_word(32'hFFFF_FFFE, 32'd1);
    send_word(32'h8000_0000, 32'h8000_0000);
    wait_for_results();
  endtask

  task automatic test_small_prime();
    write_modulus(32'd23);
    send_word(32'd5, 32'd6);
    send_word(32'd5, 32'd15);
    send_word(32'd19, 32'd6);
    wait_for_results();
  endtask

  task automatic test_written_zero();
    write_modulus(32'd0);
    send_word(32'd9, 32'd9);
    wait_for_results();
  endtask

  task automatic test_random_phases();
    logic [31:0] phase_mod[8];
    phase_mod[0] = $urandom;
    phase_mod[1] = $urandom_range(2, 1000);
    phase_mod[2] = 32'hFFFF_FFFF;
    phase_mod[3] = $urandom | 32'h8000_0000;
    phase_mod[4] = $urandom;
    phase_mod[5] = 32'd1;
    phase_mod[6] = 32'd0;
    phase_mod[7] = $urandom_range(2, 65535);
    foreach (phase_mod[p]) begin
      write_modulus(phase_mod[p]);
      repeat (33) begin
        // Now and then hold off until the block has emptied.
        if ($urandom_range(0, 39) == 0) wait_for_results();
        send_word(pick_base(), pick_exponent());
      end
      wait_for_results();
    end
  endtask

  // Result checker and receiver stall pattern.
  always @(posedge clk) begin : result_check
    out_word_t exp_w;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_residues.size() == 0) begin
          $error("unexpected result word: residue %h bad_modulus %b",
                 out_data.residue, out_data.bad_modulus);
          error_count++;
        end else begin
          exp_w = pending_residues.pop_front();
          if (out_data.residue !== exp_w.residue) begin
            $error("residue: expected %h, actual %h", exp_w.residue, out_data.residue);
            error_count++;
          end
          if (out_data.bad_modulus !== exp_w.bad_modulus) begin
            $error("bad_modulus: expected %b, actual %b",
                   exp_w.bad_modulus, out_data.bad_modulus);
            error_count++;
          end
        end
      end
      if (ready_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_left = $urandom_range(20, 400);
      end
      ready_left--;
      case (ready_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        2:       out_ready <= ($urandom_range(0, 7) == 0);
        default: out_ready <= 1'b0;
      endcase
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_modulus();
    test_tiny_moduli();
    test_wide_moduli();
    test_small_prime();
    test_written_zero();
    test_random_phases();
    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_residues.size() != 0) begin
      $error("%0d expected result words never arrived", pending_residues.size());
      error_count++;
    end
    $display("Covered %0d words under %0d modulus writes, %0d results checked.",
             words_sent, modulus_writes, results_seen);
    $display("Moduli included zero, one, two, a small prime and full-width values.");
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/modexp_pkg.sv
sv/modexp_mulmod.sv
sv/modexp_dp.sv
sv/modexp_ctrl.sv
sv/modular_exponentiation_top.sv
bench/tb_top.sv
